// ----- rtl/stq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers for the sparse table range query block.
package stq_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_MERGE_MODE    = 1'b0;
    localparam logic CFG_ACTIVE_LENGTH = 1'b1;

    localparam int          CFG_DATA_W          = 9;
    localparam logic [8:0]  ACTIVE_LENGTH_RESET = 9'd256;

    typedef struct packed {
        logic clr_step;
        logic elem_write;
        logic q_latch;
        logic rb_init;
        logic rb_next_level;
        logic rb_read;
        logic rb_write;
        logic q_read;
        logic out_load;
    } stq_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic q_error;
        logic level_ok;
        logic last_read;
        logic out_free;
    } stq_status_t;

    function automatic logic [3:0] floor_log2_9(input logic [8:0] x);
        logic [3:0] k;
        k = '0;
        for (int b = 1; b < 9; b++)
        begin
            if (x[b])
            begin
                k = 4'(b);
            end
        end
        return k;
    endfunction

endpackage

// ----- rtl/stq_in_if.sv -----
`timescale 1ns / 1ps
// Input item channel: valid/ready handshake with write and query fields.
interface stq_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [7:0]         element_index;
    logic signed [31:0] element_value;
    logic [7:0]         range_left;
    logic [8:0]         range_right;

    modport source (output valid, output opcode, output element_index,
                    output element_value, output range_left, output range_right,
                    input ready);
    modport sink   (input valid, input opcode, input element_index,
                    input element_value, input range_left, input range_right,
                    output ready);
endinterface

// ----- rtl/stq_out_if.sv -----
`timescale 1ns / 1ps
// Result channel: valid/ready handshake with query answer and error flag.
interface stq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] query_answer;
    logic               range_error;

    modport source (output valid, output query_answer, output range_error, input ready);
    modport sink   (input valid, input query_answer, input range_error, output ready);
endinterface

// ----- rtl/sparse_table_range_query.sv -----
`timescale 1ns / 1ps
// Top level of the sparse table range minimum/maximum query block.
//
//   channel  dir  handshake            beat contents
//   in_ch    in   valid/ready          opcode, element_index, element_value,
//                                      range_left, range_right
//   out_ch   out  valid/ready          query_answer, range_error
//   cfg      in   cfg_we (no wait)     cfg_index, cfg_data
//
// After reset the element store is cleared one word a cycle, with in_ch.ready low.
// A write beat is taken in S_IDLE; a query runs through S_CHECK, S_Q_READ and S_RESULT,
// an error query going from S_CHECK straight to S_RESULT.
// A query on a stale table first rebuilds it: per level, a level check, a run reading
// the entries, and a drain for the last write of the level; a final check ends the walk.
// Error queries skip the rebuild. A result waiting in the output register stalls only
// the next query's final step.
module sparse_table_range_query
    import stq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    stq_in_if.sink                in_ch,
    stq_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    stq_cmd_t    cmd;
    stq_status_t status;

    stq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    stq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element_index (in_ch.element_index),
        .element_value (in_ch.element_value),
        .range_left    (in_ch.range_left),
        .range_right   (in_ch.range_right),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .query_answer  (out_ch.query_answer),
        .range_error   (out_ch.range_error)
    );

endmodule

// ----- rtl/stq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: config registers, level memory, rebuild counters, merge and result register.
module stq_datapath
    import stq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stq_cmd_t              cmd,
    output stq_status_t           status,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]            element_index,
    input  logic signed [31:0]    element_value,
    input  logic [7:0]            range_left,
    input  logic [8:0]            range_right,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    query_answer,
    output logic                  range_error
);

    localparam int LOG2 = $clog2(DEPTH + 1) - 1;
    localparam int AW   = $clog2(DEPTH);
    localparam int LVW  = $clog2(LOG2 + 1);
    localparam int NW   = $clog2(DEPTH + 1);
    localparam int CW   = (NW > 9) ? NW : 9;
    localparam int SW   = CW + 2;
    localparam int MD   = (LOG2 + 1) << AW;
    localparam int MAW  = LVW + AW;

    logic                  merge_mode_reg;
    logic [8:0]            active_length_reg;
    logic [CW-1:0]         n_eff;

    logic [7:0]            l_reg;
    logic [8:0]            r_reg;
    logic [8:0]            span;
    logic [3:0]            k4;
    logic [LVW-1:0]        k_lvl;
    logic [8:0]            r_start;

    logic [LVW-1:0]        lvl_reg;
    logic [AW-1:0]         j_reg;
    logic [MAW-1:0]        wa_reg;
    logic [SW-1:0]         w;
    logic [SW-1:0]         two_w;
    logic [SW-1:0]         jw;

    logic [AW-1:0]         clr_reg;

    logic signed [DATA_WIDTH-1:0] mem [MD];
    logic signed [DATA_WIDTH-1:0] rd_a_reg;
    logic signed [DATA_WIDTH-1:0] rd_b_reg;
    logic signed [DATA_WIDTH-1:0] merged;
    logic signed [63:0]           ev64;
    logic signed [63:0]           m64;

    logic                  re;
    logic [MAW-1:0]        ra;
    logic [MAW-1:0]        rb;
    logic                  we;
    logic [MAW-1:0]        wa;
    logic signed [DATA_WIDTH-1:0] wd;

    logic                  out_valid_reg;
    logic signed [31:0]    answer_reg;
    logic                  error_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_mode_reg    <= 1'b0;
            active_length_reg <= ACTIVE_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MERGE_MODE:    merge_mode_reg    <= cfg_data[0];
                CFG_ACTIVE_LENGTH: active_length_reg <= cfg_data[8:0];
                default:           merge_mode_reg    <= merge_mode_reg;
            endcase
        end
    end

    assign n_eff = (CW'(active_length_reg) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(active_length_reg);

    // query range
    always_ff @(posedge clk)
    begin
        if (cmd.q_latch)
        begin
            l_reg <= range_left;
            r_reg <= range_right;
        end
    end

    assign span    = r_reg - 9'(l_reg);
    assign k4      = floor_log2_9(span);
    assign k_lvl   = LVW'(k4);
    assign r_start = r_reg - (9'd1 << k4);

    // rebuild walk: level lvl_reg, entry j_reg
    assign w     = SW'(1) << lvl_reg;
    assign two_w = w << 1;
    assign jw    = SW'(j_reg) + w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg <= '0;
            j_reg   <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.rb_init)
            begin
                lvl_reg <= '0;
                j_reg   <= '0;
            end
            else if (cmd.rb_next_level)
            begin
                lvl_reg <= lvl_reg + LVW'(1);
                j_reg   <= '0;
            end
            else if (cmd.rb_read)
            begin
                j_reg <= j_reg + AW'(1);
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
        end
    end

    // write target of the entry being read, used in the next cycle
    always_ff @(posedge clk)
    begin
        if (cmd.rb_read)
        begin
            wa_reg <= {lvl_reg + LVW'(1), j_reg};
        end
    end

    // read ports
    always_comb
    begin
        re = cmd.q_read | cmd.rb_read;
        if (cmd.q_read)
        begin
            ra = {k_lvl, AW'(l_reg)};
            rb = {k_lvl, AW'(r_start)};
        end
        else
        begin
            ra = {lvl_reg, j_reg};
            rb = {lvl_reg, AW'(jw)};
        end
    end

    // signed min or max; ties keep the second for min, the first for max
    assign merged = ((rd_a_reg < rd_b_reg) != merge_mode_reg) ? rd_a_reg : rd_b_reg;

    assign ev64 = 64'(element_value);
    assign m64  = 64'(merged);

    // write port
    always_comb
    begin
        we = 1'b0;
        wa = wa_reg;
        wd = merged;
        if (cmd.clr_step)
        begin
            we = 1'b1;
            wa = {LVW'(0), clr_reg};
            wd = '0;
        end
        else if (cmd.elem_write)
        begin
            we = (32'(element_index) < 32'(DEPTH));
            wa = {LVW'(0), AW'(element_index)};
            wd = ev64[DATA_WIDTH-1:0];
        end
        else if (cmd.rb_write)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            answer_reg <= status.q_error ? 32'sd0 : m64[31:0];
            error_reg  <= status.q_error;
        end
    end

    assign out_valid    = out_valid_reg;
    assign query_answer = answer_reg;
    assign range_error  = error_reg;

    always_comb
    begin
        status.clr_last  = (clr_reg == AW'(DEPTH - 1));
        status.q_error   = ({1'b0, l_reg} >= r_reg) || (CW'(r_reg) > n_eff);
        status.level_ok  = (two_w <= SW'(n_eff));
        status.last_read = ((SW'(j_reg) + two_w) >= SW'(n_eff));
        status.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// ----- rtl/stq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: clearing pass, item intake, table rebuild sequence and query steps.
module stq_ctrl
    import stq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_opcode,
    output logic        in_ready,
    input  logic        cfg_we,
    input  stq_status_t status,
    output stq_cmd_t    cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CHECK    = 3'd2;
    localparam logic [2:0] S_RB_LEVEL = 3'd3;
    localparam logic [2:0] S_RB_RUN   = 3'd4;
    localparam logic [2:0] S_RB_DRAIN = 3'd5;
    localparam logic [2:0] S_Q_READ   = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       current_reg;
    logic       current_next;
    logic       pend_reg;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        current_next = current_reg;
        cmd          = '0;
        cmd.rb_write = pend_reg;

        if (cfg_we)
        begin
            current_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_opcode == OP_WRITE)
                    begin
                        cmd.elem_write = 1'b1;
                        current_next   = 1'b0;
                    end
                    else
                    begin
                        cmd.q_latch = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.q_error)
                begin
                    state_next = S_RESULT;
                end
                else if (!current_reg)
                begin
                    cmd.rb_init = 1'b1;
                    state_next  = S_RB_LEVEL;
                end
                else
                begin
                    state_next = S_Q_READ;
                end
            end
            S_RB_LEVEL:
            begin
                if (status.level_ok)
                begin
                    state_next = S_RB_RUN;
                end
                else
                begin
                    current_next = 1'b1;
                    state_next   = S_Q_READ;
                end
            end
            S_RB_RUN:
            begin
                cmd.rb_read = 1'b1;
                if (status.last_read)
                begin
                    state_next = S_RB_DRAIN;
                end
            end
            S_RB_DRAIN:
            begin
                // last write of the level lands here; next level reads after it
                cmd.rb_next_level = 1'b1;
                state_next        = S_RB_LEVEL;
            end
            S_Q_READ:
            begin
                cmd.q_read = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            current_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            current_reg <= current_next;
            pend_reg    <= (state_reg == S_RB_RUN);
        end
    end

endmodule

// ----- tb/tb_sparse_table_range_query.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sparse table range min/max query block.
module tb_sparse_table_range_query;
    import stq_pkg::*;

    localparam int NUM_WORDS     = 256;
    localparam int NUM_LEVELS    = 8;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 130;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         element_index;
        logic signed [31:0] element_value;
        logic [7:0]         range_left;
        logic [8:0]         range_right;
    } request_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               err;
    } answer_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_e;

    // addr: element index, range_left or register index
    // data: element value, range_right or register value
    typedef struct packed {
        row_kind_e   kind;
        logic [8:0]  addr;
        logic [31:0] data;
        logic        check;
        logic [31:0] answer;
        logic        err;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [0:29] = '{
        // kind     addr                  data           check answer         err
        '{ROW_QUERY, 9'd0,                32'd256,        1'b1, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd5,                32'd5,          1'b1, 32'h0000_0000, 1'b1},
        '{ROW_QUERY, 9'd10,               32'd3,          1'b1, 32'h0000_0000, 1'b1},
        '{ROW_QUERY, 9'd0,                32'd257,        1'b1, 32'h0000_0000, 1'b1},
        '{ROW_QUERY, 9'd255,              32'd511,        1'b1, 32'h0000_0000, 1'b1},
        '{ROW_WRITE, 9'd0,                32'h7FFF_FFFF,  1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, 9'd255,              32'h8000_0000,  1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, 9'd128,              32'hFFFF_FFFF,  1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, 9'd7,                32'h0000_0001,  1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd256,        1'b1, 32'h8000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd1,          1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_QUERY, 9'd255,              32'd256,        1'b1, 32'h8000_0000, 1'b0},
        '{ROW_QUERY, 9'd1,                32'd255,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd127,              32'd130,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_CFG,   9'(CFG_MERGE_MODE),    32'd1,          1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd256,        1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_CFG,   9'(CFG_ACTIVE_LENGTH), 32'd0,          1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd1,          1'b1, 32'h0000_0000, 1'b1},
        '{ROW_CFG,   9'(CFG_ACTIVE_LENGTH), 32'd511,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd256,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd257,        1'b1, 32'h0000_0000, 1'b1},
        '{ROW_CFG,   9'(CFG_ACTIVE_LENGTH), 32'd1,          1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, 9'd200,              32'd12345,      1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd1,          1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd2,          1'b1, 32'h0000_0000, 1'b1},
        '{ROW_CFG,   9'(CFG_ACTIVE_LENGTH), 32'd256,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_CFG,   9'(CFG_MERGE_MODE),    32'd0,          1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd199,              32'd201,        1'b0, 32'h0000_0000, 1'b0},
        '{ROW_WRITE, 9'd3,                32'hFFFF_FFFB,  1'b0, 32'h0000_0000, 1'b0},
        '{ROW_QUERY, 9'd0,                32'd8,          1'b0, 32'h0000_0000, 1'b0}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [8:0] cfg_data;

    stq_in_if  in_ch();
    stq_out_if out_ch();

    sparse_table_range_query dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Level 0 is the element array; level k holds merges over 2**k words.
    logic signed [31:0] table_words [0:NUM_LEVELS][0:NUM_WORDS-1];
    bit                 table_ok;
    bit                 mode_max;
    logic [8:0]         act_len;

    answer_t pending_answers [$];
    int      mismatch_count;
    bit      calm;
    bit      hold_req;
    int      hold_left;

    function automatic int log2_floor(input int x);
        int k;
        k = 0;
        while (x > 1)
        begin
            x = x >> 1;
            k++;
        end
        return k;
    endfunction

    function automatic logic signed [31:0] merge_words(input logic signed [31:0] a,
                                                       input logic signed [31:0] b);
        if (mode_max)
        begin
            return (a < b) ? b : a;
        end
        return (a < b) ? a : b;
    endfunction

    // Updates the shadow store; returns 1 when the beat produces a result.
    function automatic bit predict_range_answer(input request_t rq, output answer_t ans);
        int n;
        int l;
        int r;
        int k;
        int w;
        ans = '0;
        n = (act_len > 9'(NUM_WORDS)) ? NUM_WORDS : int'(act_len);
        if (rq.opcode == OP_WRITE)
        begin
            table_words[0][rq.element_index] = rq.element_value;
            table_ok = 1'b0;
            return 1'b0;
        end
        l = rq.range_left;
        r = rq.range_right;
        if (l >= r || r > n)
        begin
            ans.err = 1'b1;
            return 1'b1;
        end
        if (!table_ok)
        begin
            for (int i = 0; i < log2_floor(n); i++)
            begin
                w = 1 << i;
                for (int j = 0; j + 2 * w <= n; j++)
                begin
                    table_words[i + 1][j] = merge_words(table_words[i][j],
                                                        table_words[i][j + w]);
                end
            end
            table_ok = 1'b1;
        end
        k = log2_floor(r - l);
        ans.answer = merge_words(table_words[k][l], table_words[k][r - (1 << k)]);
        return 1'b1;
    endfunction

    function automatic void log_mismatch(input string what, input answer_t want,
                                         input logic [31:0] got_answer, input logic got_err);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected answer %h error %b, got answer %h error %b",
                     $realtime, what, want.answer, want.err, got_answer, got_err);
        end
    endfunction

    function automatic request_t make_request(input logic op, input int n);
        request_t rq;
        rq.opcode        = op;
        rq.element_index = 8'($urandom);
        rq.element_value = 32'($urandom);
        rq.range_left    = 8'($urandom);
        rq.range_right   = 9'($urandom);
        if (op == OP_WRITE)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                rq.element_index = 8'($urandom_range(0, n - 1));
            end
            case ($urandom_range(0, 9))
                0: rq.element_value = 32'sh7FFF_FFFF;
                1: rq.element_value = 32'sh8000_0000;
                2: rq.element_value = 32'sh0000_0000;
                3: rq.element_value = -32'sd1;
                default: ;
            endcase
        end
        else if ($urandom_range(0, 99) >= 12)
        begin
            rq.range_left  = 8'($urandom_range(0, n - 1));
            rq.range_right = 9'($urandom_range(rq.range_left + 1, n));
        end
        return rq;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input request_t rq, input bit typed, input answer_t want);
        answer_t ans;
        bit      has_result;
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.opcode        <= rq.opcode;
        in_ch.element_index <= rq.element_index;
        in_ch.element_value <= rq.element_value;
        in_ch.range_left    <= rq.range_left;
        in_ch.range_right   <= rq.range_right;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        has_result = predict_range_answer(rq, ans);
        if (has_result)
        begin
            pending_answers = {pending_answers, (typed ? want : ans)};
        end
        @(negedge clk);
    endtask

    // Returns with cfg_we already low, so back-to-back writes never overlap.
    task automatic write_reg(input logic idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MERGE_MODE)
        begin
            mode_max = val[0];
        end
        else
        begin
            act_len = val;
        end
        table_ok = 1'b0;
        @(negedge clk);
    endtask

    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (pending_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: random back-pressure plus one long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial
    begin
        answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    log_mismatch("result beat with nothing expected", '0,
                                 out_ch.query_answer, out_ch.range_error);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (out_ch.query_answer !== want.answer)
                    begin
                        log_mismatch("query_answer mismatch", want,
                                     out_ch.query_answer, out_ch.range_error);
                    end
                    if (out_ch.range_error !== want.err)
                    begin
                        log_mismatch("range_error mismatch", want,
                                     out_ch.query_answer, out_ch.range_error);
                    end
                end
            end
        end
    end

    initial
    begin
        dir_row_t row;
        request_t rq;
        answer_t  want;
        int       n_eff;
        int       sent;
        int       n_wr;
        int       n_rd;
        bit       big;
        logic [8:0] len;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_MERGE_MODE;
        cfg_data            = '0;
        in_ch.valid         = 1'b0;
        in_ch.opcode        = OP_WRITE;
        in_ch.element_index = '0;
        in_ch.element_value = '0;
        in_ch.range_left    = '0;
        in_ch.range_right   = '0;
        calm                = 1'b0;
        hold_req            = 1'b0;
        mismatch_count      = 0;
        table_ok            = 1'b0;
        mode_max            = 1'b0;
        act_len             = ACTIVE_LENGTH_RESET;
        for (int i = 0; i <= NUM_LEVELS; i++)
        begin
            for (int j = 0; j < NUM_WORDS; j++)
            begin
                table_words[i][j] = '0;
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            row  = DIRECTED_ROWS[i];
            rq   = '0;
            want = '{answer: row.answer, err: row.err};
            case (row.kind)
                ROW_CFG:
                begin
                    settle_block();
                    write_reg(row.addr[0], row.data[8:0]);
                end
                ROW_WRITE:
                begin
                    rq.opcode        = OP_WRITE;
                    rq.element_index = row.addr[7:0];
                    rq.element_value = row.data;
                    send_request(rq, 1'b0, '0);
                end
                default:
                begin
                    rq.opcode      = OP_QUERY;
                    rq.range_left  = row.addr[7:0];
                    rq.range_right = row.data[8:0];
                    send_request(rq, row.check, want);
                end
            endcase
        end

        // Random phases: bursts of writes followed by queries on the fresh table.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: len = 9'd1;
                1: len = 9'd2;
                2: len = 9'($urandom_range(3, 16));
                3: len = 9'($urandom_range(17, 64));
                4: len = 9'($urandom_range(3, 64));
                5: len = 9'd256;
                6: len = 9'($urandom_range(257, 511));
                default: len = 9'($urandom_range(5, 32));
            endcase
            settle_block();
            write_reg(CFG_MERGE_MODE, 9'($urandom_range(0, 1)));
            write_reg(CFG_ACTIVE_LENGTH, len);
            n_eff = (len > 9'(NUM_WORDS)) ? NUM_WORDS : int'(len);
            // full tables rebuild slowly, so writes stay rare there
            big   = (n_eff == NUM_WORDS);
            calm  = (ph == 3);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                n_wr = big ? int'($urandom_range(0, 9) == 0) : int'($urandom_range(0, 3));
                n_rd = $urandom_range(1, 6);
                repeat (n_wr)
                begin
                    send_request(make_request(OP_WRITE, n_eff), 1'b0, '0);
                    sent++;
                end
                repeat (n_rd)
                begin
                    send_request(make_request(OP_QUERY, n_eff), 1'b0, '0);
                    sent++;
                end
            end
        end
        calm = 1'b0;

        settle_block();
        if (mismatch_count == 0 && pending_answers.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
